// ----- design/eda_pkg.sv -----
// ----------------------------------------------------------------------------
// eda_pkg - shared types and constants
// Character codes, digit sizing and the status group of the iterative units.
// ----------------------------------------------------------------------------
`default_nettype none

package eda_pkg;

  localparam int unsigned EDA_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned STEP_W     = 5;

  localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHR_MUL   = 8'h78;
  localparam logic [CHAR_W-1:0] CHR_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CHR_MOD   = 8'h25;
  localparam logic [CHAR_W-1:0] CHR_EQ    = 8'h3D;

  localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

  typedef logic [EDA_DIGITS-1:0][DIGIT_W-1:0] bcd_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eda_unit_sts_t;

endpackage

`default_nettype wire

// ----- design/eda_div.sv -----
// ----------------------------------------------------------------------------
// eda_div - radix-2 restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module eda_div import eda_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire  [WORD_W-1:0]   dividend,
  input  wire  [WORD_W-1:0]   divisor,
  output eda_unit_sts_t       sts,
  output logic [WORD_W-1:0]   quotient,
  output logic [WORD_W-1:0]   remainder
);

  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dsr_r, dsr_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              fits;

  always_comb begin
    shifted  = {rem_r, quo_r[WORD_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    fits     = shifted >= {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- design/eda_bcd.sv -----
// ----------------------------------------------------------------------------
// eda_bcd - shift-and-add-3 binary to BCD converter
// One bit shifted in per cycle, a whole word per pass; reused for every number.
// ----------------------------------------------------------------------------
`default_nettype none

module eda_bcd import eda_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire  [WORD_W-1:0]   value,
  output eda_unit_sts_t       sts,
  output bcd_word_t           digits
);

  logic [WORD_W-1:0] bin_r, bin_nxt;
  bcd_word_t         bcd_r, bcd_nxt;
  bcd_word_t         bcd_adj;
  logic [EDA_DIGITS*DIGIT_W-1:0] bcd_flat;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < EDA_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_flat = bcd_adj;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {bcd_flat[EDA_DIGITS*DIGIT_W-2:0], bin_r[WORD_W-1]};
      bin_nxt = {bin_r[WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign digits   = bcd_r;

endmodule

`default_nettype wire

// ----- design/equation_to_decimal_ascii.sv -----
// Equation printer: 'A op B =' then the result if any, one decimal ASCII char per transaction.
// The first character follows the BCD pass of the first operand and the dropped leading zeros.
// Each equation takes up to three BCD passes (two when it ends at '='), ten digit slots per
//   number, and a divide for / and % with a nonzero divisor; back-pressure can stretch it.
// Input is taken only between equations; the output register decouples the sides.
// Reset (synchronous, active low) returns the sequencer to idle and drops out_tvalid.
// ----------------------------------------------------------------------------
// equation_to_decimal_ascii - top level sequencer
// Latches the operands, drives the shared BCD converter and the divider, and
// emits the equation text through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module equation_to_decimal_ascii import eda_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,   // first_operand[31:0], operation[39:32], second_operand[71:40]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // character[7:0]
  output logic        out_tlast,
  output logic        out_tuser   // divide_by_zero[0]
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CONV = 7'b0000010,
    S_NUM  = 7'b0000100,
    S_OP   = 7'b0001000,
    S_EQ   = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_RES  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    PART_A,
    PART_B,
    PART_RES
  } part_t;

  state_t            state_r, state_nxt;
  part_t             part_r, part_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              started_r, started_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [CHAR_W-1:0] op_r, op_nxt;
  logic [WORD_W-1:0] value_r, value_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;
  logic              ouser_r, ouser_nxt;

  logic              bcd_start;
  logic [WORD_W-1:0] bcd_value;
  eda_unit_sts_t     bcd_sts;
  bcd_word_t         bcd_digits;
  logic              div_start;
  eda_unit_sts_t     div_sts;
  logic [WORD_W-1:0] div_quo;
  logic [WORD_W-1:0] div_rem;

  logic              slot_free;
  logic [DIGIT_W-1:0] digit;
  logic              show;
  logic              is_add, is_sub, is_mul, is_div, is_mod;
  logic              known_op, div_zero, ends_at_eq;
  logic [WORD_W-1:0] arith;

  eda_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .value  (bcd_value),
    .sts    (bcd_sts),
    .digits (bcd_digits)
  );

  eda_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (a_r),
    .divisor   (b_r),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    slot_free  = !ovalid_r || out_tready;
    digit      = bcd_digits[idx_r];
    show       = started_r || (digit != '0) || (idx_r == '0);
    is_add     = op_r == CHR_PLUS;
    is_sub     = op_r == CHR_MINUS;
    is_mul     = op_r == CHR_MUL;
    is_div     = op_r == CHR_DIV;
    is_mod     = op_r == CHR_MOD;
    known_op   = is_add || is_sub || is_mul || is_div || is_mod;
    div_zero   = (is_div || is_mod) && (b_r == '0);
    ends_at_eq = !known_op || div_zero;
    if (is_add)      arith = a_r + b_r;
    else if (is_sub) arith = a_r - b_r;
    else             arith = a_r * b_r;

    state_nxt   = state_r;
    part_nxt    = part_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    op_nxt      = op_r;
    value_nxt   = value_r;
    bcd_start   = 1'b0;
    bcd_value   = value_r;
    div_start   = 1'b0;
    ovalid_nxt  = ovalid_r && !out_tready;
    ochar_nxt   = ochar_r;
    olast_nxt   = olast_r;
    ouser_nxt   = ouser_r;
    in_tready   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        bcd_value = in_tdata[31:0];
        if (in_tvalid) begin
          a_nxt     = in_tdata[31:0];
          op_nxt    = in_tdata[39:32];
          b_nxt     = in_tdata[71:40];
          bcd_start = 1'b1;
          part_nxt  = PART_A;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (bcd_sts.done) begin
          idx_nxt     = 4'(EDA_DIGITS - 1);
          started_nxt = 1'b0;
          state_nxt   = S_NUM;
        end
      end
      S_NUM: begin
        if (!show) begin
          // drop leading zero
          idx_nxt = idx_r - 1'b1;
        end else if (slot_free) begin
          ovalid_nxt  = 1'b1;
          ochar_nxt   = CHR_ZERO + {4'b0, digit};
          olast_nxt   = 1'b0;
          ouser_nxt   = 1'b0;
          started_nxt = 1'b1;
          idx_nxt     = idx_r - 1'b1;
          if (idx_r == '0) begin
            case (part_r)
              PART_A:   state_nxt = S_OP;
              PART_B:   state_nxt = S_EQ;
              default: begin
                olast_nxt = 1'b1;
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      S_OP: begin
        bcd_value = b_r;
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = op_r;
          olast_nxt  = 1'b0;
          ouser_nxt  = 1'b0;
          bcd_start  = 1'b1;
          part_nxt   = PART_B;
          state_nxt  = S_CONV;
        end
      end
      S_EQ: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = CHR_EQ;
          olast_nxt  = ends_at_eq;
          ouser_nxt  = div_zero;
          if (ends_at_eq) begin
            state_nxt = S_IDLE;
          end else if (is_div || is_mod) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            value_nxt = arith;
            state_nxt = S_RES;
          end
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          value_nxt = is_mod ? div_rem : div_quo;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        bcd_start = 1'b1;
        part_nxt  = PART_RES;
        state_nxt = S_CONV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      part_r   <= PART_A;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      part_r   <= part_nxt;
      ovalid_r <= ovalid_nxt;
    end
    idx_r     <= idx_nxt;
    started_r <= started_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    op_r      <= op_nxt;
    value_r   <= value_nxt;
    ochar_r   <= ochar_nxt;
    olast_r   <= olast_nxt;
    ouser_r   <= ouser_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

endmodule

`default_nettype wire

// ----- tb/equation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equation_checker - scoreboard for the equation printer
// Watches both stream channels, builds the expected character text of every
// accepted equation and compares each output transaction field by field.
// ----------------------------------------------------------------------------

module equation_checker import eda_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [71:0] in_tdata,   // first_operand[31:0], operation[39:32], second_operand[71:40]
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [7:0]  out_tdata,  // character[7:0]
  input  wire        out_tlast,
  input  wire        out_tuser,  // divide_by_zero[0]
  output int         mismatches,
  output int         chars_owed
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              div_zero;
  } eq_char_t;

  eq_char_t text_q[$];
  int       fail_cnt = 0;

  assign mismatches = fail_cnt;

  // Decimal text of a word, most significant digit first; returns its length.
  function automatic int to_decimal(input logic [WORD_W-1:0] value,
                                    output logic [CHAR_W-1:0] txt [EDA_DIGITS]);
    logic [CHAR_W-1:0] rev [EDA_DIGITS];
    logic [WORD_W-1:0] v;
    int                n;
    v = value;
    n = 0;
    for (int i = 0; i < EDA_DIGITS; i++) begin
      txt[i] = '0;
      rev[i] = '0;
    end
    if (v == '0) begin
      txt[0] = CHR_ZERO;
      return 1;
    end
    while (v != '0) begin
      rev[n] = CHR_ZERO + CHAR_W'(v % 10);
      v = v / 10;
      n++;
    end
    for (int i = 0; i < n; i++) txt[i] = rev[n-1-i];
    return n;
  endfunction

  task automatic predict_equation(input logic [71:0] item);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] res;
    logic [CHAR_W-1:0] op;
    logic [CHAR_W-1:0] line [32];
    logic [CHAR_W-1:0] num [EDA_DIGITS];
    int                len;
    int                k;
    logic              has_res;
    logic              dz;
    a       = item[31:0];
    op      = item[39:32];
    b       = item[71:40];
    len     = 0;
    has_res = 1'b1;
    dz      = 1'b0;
    res     = '0;
    for (int i = 0; i < 32; i++) line[i] = '0;

    k = to_decimal(a, num);
    for (int i = 0; i < k; i++) begin
      line[len] = num[i];
      len++;
    end
    line[len] = op;
    len++;
    k = to_decimal(b, num);
    for (int i = 0; i < k; i++) begin
      line[len] = num[i];
      len++;
    end
    line[len] = CHR_EQ;
    len++;

    case (op)
      CHR_PLUS:  res = a + b;
      CHR_MINUS: res = a - b;
      CHR_MUL:   res = a * b;
      CHR_DIV, CHR_MOD: begin
        if (b == '0) begin
          has_res = 1'b0;
          dz      = 1'b1;
        end else begin
          res = (op == CHR_DIV) ? a / b : a % b;
        end
      end
      default:   has_res = 1'b0;
    endcase

    if (has_res) begin
      k = to_decimal(res, num);
      for (int i = 0; i < k; i++) begin
        line[len] = num[i];
        len++;
      end
    end

    // Flag the closing character; the divide-by-zero flag rides only there
    for (int i = 0; i < len; i++)
      text_q.push_back('{ch: line[i], last: (i == len - 1), div_zero: (i == len - 1) && dz});
  endtask

  always @(posedge clk) begin
    eq_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_equation(in_tdata);
      if (out_tvalid && out_tready) begin
        if (text_q.size() == 0) begin
          $error("character: expected none, got %h", out_tdata);
          fail_cnt++;
        end else begin
          want = text_q.pop_front();
          if (out_tdata !== want.ch) begin
            $error("character: expected %h, got %h", want.ch, out_tdata);
            fail_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_tlast);
            fail_cnt++;
          end
          if (out_tuser !== want.div_zero) begin
            $error("divide_by_zero: expected %b, got %b", want.div_zero, out_tuser);
            fail_cnt++;
          end
        end
      end
    end
    chars_owed <= text_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the equation printer
// Sends directed corner equations, then random ones with bursty idling on
// both channels; the checker predicts and compares the character stream.
// ----------------------------------------------------------------------------

module testbench;
  import eda_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // first_operand[31:0], operation[39:32], second_operand[71:40]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // character[7:0]
  logic        out_tlast;
  logic        out_tuser;  // divide_by_zero[0]

  int          mismatches;
  int          chars_owed;
  logic        idle_en = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  equation_to_decimal_ascii u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  equation_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .chars_owed (chars_owed)
  );

  // Receiver back-pressure in random bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abort when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_equation(input logic [31:0] a, input logic [7:0] op,
                               input logic [31:0] b);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, op, a};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every predicted character has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] pow10 [10];
    pow10 = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
              32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};
    case ($urandom_range(0, 6))
      0:       return $urandom();
      1:       return $urandom_range(0, 9);
      2:       return $urandom_range(0, 999);
      3:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      4:       return pow10[$urandom_range(0, 9)] - $urandom_range(0, 1);
      5:       return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_operation();
    logic [7:0] ops [5];
    ops = '{CHR_PLUS, CHR_MINUS, CHR_MUL, CHR_DIV, CHR_MOD};
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return ops[$urandom_range(0, 4)];
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  op;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero, widest numbers, wrap, divide by zero, unknown operators
    send_equation(32'd0,          CHR_PLUS,  32'd0);
    send_equation(32'hFFFF_FFFF,  CHR_PLUS,  32'hFFFF_FFFF);
    send_equation(32'hFFFF_FFFF,  CHR_PLUS,  32'd1);
    send_equation(32'd1000000000, CHR_PLUS,  32'd0);
    send_equation(32'd9,          CHR_PLUS,  32'd1);
    send_equation(32'd0,          CHR_MINUS, 32'd1);
    send_equation(32'd5,          CHR_MINUS, 32'd5);
    send_equation(32'hFFFF_FFFF,  CHR_MUL,   32'hFFFF_FFFF);
    send_equation(32'h0001_0000,  CHR_MUL,   32'h0001_0000);
    send_equation(32'd123456789,  CHR_MUL,   32'd10);
    send_equation(32'hFFFF_FFFF,  CHR_DIV,   32'd1);
    send_equation(32'd3,          CHR_DIV,   32'd10);
    send_equation(32'd7,          CHR_DIV,   32'd0);
    send_equation(32'd0,          CHR_DIV,   32'd0);
    send_equation(32'hFFFF_FFFF,  CHR_MOD,   32'd0);
    send_equation(32'd1000000000, CHR_MOD,   32'd7);
    send_equation(32'd10,         CHR_MOD,   32'd10);
    send_equation(32'hFFFF_FFFF,  CHR_MOD,   32'hFFFF_FFFE);
    send_equation(32'd42,         8'h00,     32'd17);
    send_equation(32'hFFFF_FFFF,  8'hFF,     32'hFFFF_FFFF);
    send_equation(32'd1,          CHR_EQ,    32'd0);
    send_equation(32'd0,          8'h80,     32'd0);
    wait_drained();

    for (int blk = 0; blk < 19; blk++) begin
      idle_en <= (blk >= 16) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (blk == 9) wait_drained();
      for (int i = 0; i < 20; i++) begin
        a  = pick_operand();
        op = pick_operation();
        b  = pick_operand();
        if ((op == CHR_DIV || op == CHR_MOD) && $urandom_range(0, 9) == 0) b = '0;
        send_equation(a, op, b);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && chars_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/eda_pkg.sv
design/eda_div.sv
design/eda_bcd.sv
design/equation_to_decimal_ascii.sv
tb/equation_checker.sv
tb/testbench.sv
